/* rtl/bumc_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// bumc_pkg
// Shared types, sizes and a helper function for the unique member counter.
// ============================================================================
package bumc_pkg;

  // Sizing of the two membership bitmaps.
  localparam int MAX_ALIGNMENTS = 4096;
  localparam int WORD_BITS      = 64;
  localparam int WORD_SH        = $clog2(WORD_BITS);
  localparam int MAP_WORDS      = (MAX_ALIGNMENTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WCNT_W         = $clog2(MAP_WORDS + 1);

  // Port widths fixed by the interface.
  localparam int OP_W     = 2;
  localparam int IDX_W    = 12;
  localparam int CFG_W    = 13;
  localparam int CNT_W    = 16;
  localparam int UNIQUE_W = 13;

  localparam logic [CFG_W-1:0] CFG_RESET  = 13'd4096;
  localparam int               UNIQUE_MAX = 8191;

  // Effective size arithmetic runs at a width that holds both the register
  // and the largest allowed size.
  localparam int SIZE_W = $clog2(MAX_ALIGNMENTS + 1);
  localparam int SZ_W   = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;

  // Popcount pipeline: one partial count per byte of a word.
  localparam int BYTES  = WORD_BITS / 8;
  localparam int BPOP_W = 4;
  localparam int POP_W  = $clog2(WORD_BITS + 1);
  localparam int ACC_W  = $clog2(MAX_ALIGNMENTS + 1);
  localparam int SAT_W  = (ACC_W > UNIQUE_W) ? ACC_W : UNIQUE_W;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_COUNT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CLEAR = 6'b000100,
    S_SETRD = 6'b001000,
    S_SETWR = 6'b010000,
    S_COUNT = 6'b100000
  } state_t;

  typedef logic [BPOP_W-1:0] bpop_t;

  // Number of ones in one byte.
  function automatic bpop_t pop8(input logic [7:0] v);
    bpop_t n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + bpop_t'(v[i]);
    end
    return n;
  endfunction

endpackage

/* rtl/bumc_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// bumc_ram
// Generic single-clock RAM with one write port and one registered read port.
// ============================================================================
module bumc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

/* rtl/bitset_unique_member_counter.sv */
`timescale 1ns / 1ps
// ============================================================================
// bitset_unique_member_counter
// Two membership bitmaps with saturating member counters and an A-not-B count.
// ============================================================================
// Usage:
//   A command beat is taken at the rising edge where start is high and busy is
//   low. in_op selects the command: clear a bitmap, mark one member, or count
//   the members of A that are not in B. in_target_set picks the bitmap for
//   clear and mark; in_bit_index is the member position to mark.
//   Every command returns exactly one result beat: out_valid is high for one
//   cycle with out_unique_count, out_member_count and out_bad_index. The
//   receiver cannot stall, so the result is taken in that cycle. busy drops in
//   the same cycle the result appears, so the next command may start there.
//   An out-of-range mark, the unused op code and a count with no words in use
//   are answered from idle; a mark reads then writes the word, a clear sweeps
//   all MAP_WORDS words, and a count feeds each word pair in use to popcount.
//   The count is bound by the single read port of each bitmap RAM: one word
//   pair per cycle, followed by a two-stage popcount pipeline. A clear writes
//   one word per cycle through the write port.
//   After reset both bitmaps are swept to zero, one word per cycle, over all
//   MAP_WORDS (64) words with busy high. The configuration channel (size of
//   the member space) is always ready, also during that sweep.
// ============================================================================
module bitset_unique_member_counter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bumc_pkg::OP_W-1:0]     in_op,
  input  logic                          in_target_set,
  input  logic [bumc_pkg::IDX_W-1:0]    in_bit_index,
  output logic                          out_valid,
  output logic [bumc_pkg::UNIQUE_W-1:0] out_unique_count,
  output logic [bumc_pkg::CNT_W-1:0]    out_member_count,
  output logic                          out_bad_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bumc_pkg::CFG_W-1:0]    cfg_alignments_in_use
);

  localparam logic [bumc_pkg::WORD_AW-1:0] LAST_WORD =
    bumc_pkg::WORD_AW'(bumc_pkg::MAP_WORDS - 1);
  localparam logic [bumc_pkg::CNT_W-1:0] CNT_MAX = '1;

  // Control state.
  bumc_pkg::state_t                 state_r, state_nxt;
  logic [bumc_pkg::WORD_AW-1:0]     addr_r, addr_nxt;
  logic                             tgt_r, tgt_nxt;
  logic [bumc_pkg::WORD_SH-1:0]     bit_r, bit_nxt;
  logic [bumc_pkg::WCNT_W-1:0]      words_r, words_nxt;
  logic                             issue_done_r, issue_done_nxt;
  logic                             p1_vld_r, p1_vld_nxt;
  logic                             p2_vld_r;
  logic [bumc_pkg::ACC_W-1:0]       acc_r, acc_nxt;
  logic [bumc_pkg::CNT_W-1:0]       cnt_a_r, cnt_a_nxt;
  logic [bumc_pkg::CNT_W-1:0]       cnt_b_r, cnt_b_nxt;
  logic [bumc_pkg::CFG_W-1:0]       align_r;

  // Result registers.
  logic                             out_valid_r, out_valid_nxt;
  logic [bumc_pkg::UNIQUE_W-1:0]    out_unique_r, out_unique_nxt;
  logic [bumc_pkg::CNT_W-1:0]       out_member_r, out_member_nxt;
  logic                             out_bad_r, out_bad_nxt;

  // Popcount pipeline payload.
  bumc_pkg::bpop_t                  bpop_r [bumc_pkg::BYTES];
  logic [bumc_pkg::POP_W-1:0]       word_pop;

  // RAM ports.
  logic                             we_a, we_b;
  logic [bumc_pkg::WORD_AW-1:0]     ram_raddr, ram_waddr;
  logic [bumc_pkg::WORD_BITS-1:0]   ram_wdata;
  logic [bumc_pkg::WORD_BITS-1:0]   rdata_a, rdata_b;
  logic [bumc_pkg::WORD_BITS-1:0]   diff_word;

  // Size derived from the configuration register.
  logic [bumc_pkg::SZ_W-1:0]        cfg_ext;
  logic [bumc_pkg::SZ_W-1:0]        eff_size;
  logic [bumc_pkg::SZ_W:0]          size_round;
  logic [bumc_pkg::WCNT_W-1:0]      words_in_use;
  logic                             idx_bad;
  logic [bumc_pkg::WORD_AW-1:0]     idx_word;
  logic [bumc_pkg::CNT_W-1:0]       in_cnt;
  logic [bumc_pkg::CNT_W-1:0]       tgt_cnt;
  logic [bumc_pkg::CNT_W-1:0]       tgt_cnt_inc;
  logic [bumc_pkg::WORD_BITS-1:0]   set_mask;
  logic [bumc_pkg::SAT_W-1:0]       acc_ext;

  bumc_ram #(
    .WIDTH (bumc_pkg::WORD_BITS),
    .DEPTH (bumc_pkg::MAP_WORDS)
  ) u_ram_a (
    .clk     (clk),
    .we      (we_a),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (rdata_a)
  );

  bumc_ram #(
    .WIDTH (bumc_pkg::WORD_BITS),
    .DEPTH (bumc_pkg::MAP_WORDS)
  ) u_ram_b (
    .clk     (clk),
    .we      (we_b),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (rdata_b)
  );

  // A register value above the bitmap capacity acts as the capacity.
  assign cfg_ext      = bumc_pkg::SZ_W'(align_r);
  assign eff_size     = (cfg_ext > bumc_pkg::SZ_W'(bumc_pkg::MAX_ALIGNMENTS)) ?
                        bumc_pkg::SZ_W'(bumc_pkg::MAX_ALIGNMENTS) : cfg_ext;
  assign size_round   = {1'b0, eff_size} + (bumc_pkg::SZ_W + 1)'(bumc_pkg::WORD_BITS - 1);
  assign words_in_use = bumc_pkg::WCNT_W'(size_round >> bumc_pkg::WORD_SH);
  assign idx_bad      = bumc_pkg::SZ_W'(in_bit_index) >= eff_size;
  assign idx_word     = bumc_pkg::WORD_AW'(in_bit_index >> bumc_pkg::WORD_SH);
  assign in_cnt       = in_target_set ? cnt_b_r : cnt_a_r;
  assign tgt_cnt      = tgt_r ? cnt_b_r : cnt_a_r;
  assign tgt_cnt_inc  = (tgt_cnt == CNT_MAX) ? tgt_cnt : tgt_cnt + 1'b1;
  assign set_mask     = bumc_pkg::WORD_BITS'(1) << bit_r;
  assign acc_ext      = bumc_pkg::SAT_W'(acc_r);

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    tgt_nxt        = tgt_r;
    bit_nxt        = bit_r;
    words_nxt      = words_r;
    issue_done_nxt = issue_done_r;
    p1_vld_nxt     = 1'b0;
    acc_nxt        = acc_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    out_valid_nxt  = 1'b0;
    out_unique_nxt = out_unique_r;
    out_member_nxt = out_member_r;
    out_bad_nxt    = out_bad_r;
    we_a           = 1'b0;
    we_b           = 1'b0;
    ram_raddr      = addr_r;
    ram_waddr      = addr_r;
    ram_wdata      = '0;

    unique case (state_r)
      bumc_pkg::S_INIT: begin
        // Power-up sweep: zero both bitmaps one word per cycle.
        we_a     = 1'b1;
        we_b     = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_WORD) begin
          addr_nxt  = '0;
          state_nxt = bumc_pkg::S_IDLE;
        end
      end

      bumc_pkg::S_IDLE: begin
        if (start) begin
          tgt_nxt = in_target_set;
          bit_nxt = in_bit_index[bumc_pkg::WORD_SH-1:0];
          unique case (bumc_pkg::op_t'(in_op))
            bumc_pkg::OP_CLEAR: begin
              // The counter clears at once; the bitmap clears over the sweep.
              if (in_target_set) begin
                cnt_b_nxt = '0;
              end else begin
                cnt_a_nxt = '0;
              end
              addr_nxt  = '0;
              state_nxt = bumc_pkg::S_CLEAR;
            end
            bumc_pkg::OP_SET: begin
              if (idx_bad) begin
                out_valid_nxt  = 1'b1;
                out_unique_nxt = '0;
                out_member_nxt = in_cnt;
                out_bad_nxt    = 1'b1;
              end else begin
                addr_nxt  = idx_word;
                state_nxt = bumc_pkg::S_SETRD;
              end
            end
            bumc_pkg::OP_COUNT: begin
              if (words_in_use == '0) begin
                out_valid_nxt  = 1'b1;
                out_unique_nxt = '0;
                out_member_nxt = in_cnt;
                out_bad_nxt    = 1'b0;
              end else begin
                addr_nxt       = '0;
                acc_nxt        = '0;
                words_nxt      = words_in_use;
                issue_done_nxt = 1'b0;
                state_nxt      = bumc_pkg::S_COUNT;
              end
            end
            bumc_pkg::OP_NONE: begin
              out_valid_nxt  = 1'b1;
              out_unique_nxt = '0;
              out_member_nxt = in_cnt;
              out_bad_nxt    = 1'b0;
            end
          endcase
        end
      end

      bumc_pkg::S_CLEAR: begin
        we_a     = ~tgt_r;
        we_b     = tgt_r;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_WORD) begin
          addr_nxt       = '0;
          state_nxt      = bumc_pkg::S_IDLE;
          out_valid_nxt  = 1'b1;
          out_unique_nxt = '0;
          out_member_nxt = tgt_cnt;
          out_bad_nxt    = 1'b0;
        end
      end

      bumc_pkg::S_SETRD: begin
        // The read of the target word is issued here; data arrives next cycle.
        state_nxt = bumc_pkg::S_SETWR;
      end

      bumc_pkg::S_SETWR: begin
        // Read-modify-write of the word, then the saturating counter bump.
        we_a      = ~tgt_r;
        we_b      = tgt_r;
        ram_wdata = (tgt_r ? rdata_b : rdata_a) | set_mask;
        if (tgt_r) begin
          cnt_b_nxt = tgt_cnt_inc;
        end else begin
          cnt_a_nxt = tgt_cnt_inc;
        end
        state_nxt      = bumc_pkg::S_IDLE;
        out_valid_nxt  = 1'b1;
        out_unique_nxt = '0;
        out_member_nxt = tgt_cnt_inc;
        out_bad_nxt    = 1'b0;
      end

      bumc_pkg::S_COUNT: begin
        // Issue one word pair per cycle, then drain the popcount pipeline.
        if (!issue_done_r) begin
          p1_vld_nxt = 1'b1;
          addr_nxt   = addr_r + 1'b1;
          if (bumc_pkg::WCNT_W'(addr_r) + 1'b1 == words_r) begin
            issue_done_nxt = 1'b1;
          end
        end
        if (p2_vld_r) begin
          acc_nxt = acc_r + bumc_pkg::ACC_W'(word_pop);
        end
        if (issue_done_r && !p1_vld_r && !p2_vld_r) begin
          state_nxt      = bumc_pkg::S_IDLE;
          addr_nxt       = '0;
          out_valid_nxt  = 1'b1;
          out_unique_nxt = (acc_ext > bumc_pkg::SAT_W'(bumc_pkg::UNIQUE_MAX)) ?
                           bumc_pkg::UNIQUE_W'(bumc_pkg::UNIQUE_MAX) :
                           bumc_pkg::UNIQUE_W'(acc_r);
          out_member_nxt = tgt_cnt;
          out_bad_nxt    = 1'b0;
        end
      end

      default: begin
        state_nxt = bumc_pkg::S_IDLE;
      end
    endcase
  end

  // Second popcount stage: add up the eight byte counts of one word.
  always_comb begin
    word_pop = '0;
    for (int i = 0; i < bumc_pkg::BYTES; i++) begin
      word_pop = word_pop + bumc_pkg::POP_W'(bpop_r[i]);
    end
  end

  assign diff_word = rdata_a & ~rdata_b;

  // First popcount stage: per-byte counts of A AND NOT B.
  always_ff @(posedge clk) begin
    for (int i = 0; i < bumc_pkg::BYTES; i++) begin
      bpop_r[i] <= bumc_pkg::pop8(diff_word[i*8 +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bumc_pkg::S_INIT;
      addr_r       <= '0;
      issue_done_r <= 1'b1;
      p1_vld_r     <= 1'b0;
      p2_vld_r     <= 1'b0;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      align_r      <= bumc_pkg::CFG_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      issue_done_r <= issue_done_nxt;
      p1_vld_r     <= p1_vld_nxt;
      p2_vld_r     <= p1_vld_r;
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        align_r <= cfg_alignments_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    tgt_r        <= tgt_nxt;
    bit_r        <= bit_nxt;
    words_r      <= words_nxt;
    acc_r        <= acc_nxt;
    out_unique_r <= out_unique_nxt;
    out_member_r <= out_member_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  assign busy             = (state_r != bumc_pkg::S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_unique_count = out_unique_r;
  assign out_member_count = out_member_r;
  assign out_bad_index    = out_bad_r;

  // An accepted command keeps the block busy or answers in the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command neither in progress nor answered");

  // Every result leaves the block idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while the block is still busy");

  // A flagged index never comes with a count.
  a_bad_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_index) |-> (out_unique_count == '0))
    else $error("bad index result carries a nonzero unique count");

  // Only the power-up sweep writes both bitmaps at once.
  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    (we_a && we_b) |-> (state_r == bumc_pkg::S_INIT))
    else $error("both bitmaps written outside the power-up sweep");

endmodule
